### sv/bsop_pkg.sv
`default_nettype none
package bsop_pkg;

	localparam int unsigned SET_W = 64;
	localparam int unsigned IDX_W = 7;
	localparam int unsigned Q_W   = 6;
	localparam int unsigned OP_W  = 4;

	localparam logic [IDX_W-1:0] SIZE_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_AND        = 4'd0,
		OP_OR         = 4'd1,
		OP_ANDNOT     = 4'd2,
		OP_DISJOINT   = 4'd3,
		OP_SUBSET     = 4'd4,
		OP_INTERSECTS = 4'd5,
		OP_EQ         = 4'd6,
		OP_NE         = 4'd7,
		OP_LESS       = 4'd8,
		OP_POPCOUNT   = 4'd9,
		OP_ISZERO     = 4'd10,
		OP_FIRST      = 4'd11,
		OP_LAST       = 4'd12,
		OP_NEXT       = 4'd13,
		OP_FIRSTOUT   = 4'd14
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [SET_W-1:0] set_a;
		logic [SET_W-1:0] set_b;
		logic [Q_W-1:0]   query_index;
	} req_t;

	typedef struct packed {
		logic [SET_W-1:0] result_set;
		logic             result_flag;
		logic [IDX_W-1:0] result_index;
		logic             bad_index;
	} rsp_t;

	// operands after masking to the live bits
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SET_W-1:0] a;
		logic [SET_W-1:0] b;
		logic [SET_W-1:0] mask;
		logic [Q_W-1:0]   q;
		logic [IDX_W-1:0] n;
		logic             bad;
	} s1_t;

	// finished set and flag results plus what the final reduction needs
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] n;
		logic             bad;
		logic [SET_W-1:0] rset;
		logic             rflag;
	} s2_t;

endpackage
`default_nettype wire

### sv/bsop_front.sv
`default_nettype none
module bsop_front #(
	parameter int unsigned SET_BITS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        adv,
	input  wire bsop_pkg::req_t              req,
	input  wire logic [bsop_pkg::IDX_W-1:0]  set_size,
	output bsop_pkg::s1_t                    s1
);

	localparam logic [bsop_pkg::IDX_W-1:0] MAX_N = bsop_pkg::IDX_W'(SET_BITS);

	logic [bsop_pkg::IDX_W-1:0] n;
	logic [bsop_pkg::SET_W-1:0] mask;
	bsop_pkg::s1_t              nxt;

	// saturate the size, then build the live mask
	always_comb begin
		n = (set_size > MAX_N) ? MAX_N : set_size;
		if (n >= bsop_pkg::IDX_W'(bsop_pkg::SET_W)) begin
			mask = '1;
		end else begin
			mask = (bsop_pkg::SET_W'(1) << n[5:0]) - bsop_pkg::SET_W'(1);
		end
		nxt.op   = req.opcode;
		nxt.a    = req.set_a & mask;
		nxt.b    = req.set_b & mask;
		nxt.mask = mask;
		nxt.q    = req.query_index;
		nxt.n    = n;
		nxt.bad  = (bsop_pkg::op_t'(req.opcode) == bsop_pkg::OP_NEXT)
			&& ({1'b0, req.query_index} >= n);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

### sv/bsop_eval.sv
`default_nettype none
module bsop_eval #(
	parameter int unsigned SET_BITS = 64,
	parameter int unsigned NGRP     = (SET_BITS + 7) / 8
) (
	input  wire logic              clk,
	input  wire logic              adv,
	input  wire bsop_pkg::s1_t     s1,
	output bsop_pkg::s2_t          ctl_s2,
	output logic [NGRP-1:0]        nz_s2,
	output logic [NGRP-1:0][2:0]   pos_s2,
	output logic [NGRP-1:0][3:0]   cnt_s2
);

	logic [bsop_pkg::SET_W-1:0] sv;
	logic [bsop_pkg::SET_W-1:0] rev;
	logic [bsop_pkg::SET_W-1:0] diff;
	logic [bsop_pkg::SET_W-1:0] low;
	logic [bsop_pkg::SET_W-1:0] above;
	logic [7:0]                 grp;
	logic [7:0]                 abyte;
	bsop_pkg::s2_t              ctl;
	logic [NGRP-1:0]            nz;
	logic [NGRP-1:0][2:0]       pos;
	logic [NGRP-1:0][3:0]       cnt;

	always_comb begin
		rev = '0;
		for (int i = 0; i < SET_BITS; i++) begin
			rev[i] = s1.a[SET_BITS-1-i];
		end
		diff  = s1.a ^ s1.b;
		low   = diff & (~diff + bsop_pkg::SET_W'(1));
		// bits strictly above q
		above = ~((bsop_pkg::SET_W'(2) << s1.q) - bsop_pkg::SET_W'(1));

		ctl.op    = s1.op;
		ctl.n     = s1.n;
		ctl.bad   = s1.bad;
		ctl.rset  = '0;
		ctl.rflag = 1'b0;
		sv        = '0;
		case (bsop_pkg::op_t'(s1.op))
			bsop_pkg::OP_AND:        ctl.rset  = s1.a & s1.b;
			bsop_pkg::OP_OR:         ctl.rset  = s1.a | s1.b;
			bsop_pkg::OP_ANDNOT:     ctl.rset  = s1.a & ~s1.b;
			bsop_pkg::OP_DISJOINT:   ctl.rflag = ~|(s1.a & s1.b);
			bsop_pkg::OP_SUBSET:     ctl.rflag = ~|(s1.a & ~s1.b);
			bsop_pkg::OP_INTERSECTS: ctl.rflag = |(s1.a & s1.b);
			bsop_pkg::OP_EQ:         ctl.rflag = (s1.a == s1.b);
			bsop_pkg::OP_NE:         ctl.rflag = (s1.a != s1.b);
			bsop_pkg::OP_LESS:       ctl.rflag = |(s1.a & low);
			bsop_pkg::OP_ISZERO:     ctl.rflag = ~|s1.a;
			bsop_pkg::OP_FIRST:      sv = s1.a;
			bsop_pkg::OP_LAST:       sv = rev;
			bsop_pkg::OP_NEXT:       sv = s1.a & above;
			bsop_pkg::OP_FIRSTOUT:   sv = ~s1.a & s1.mask;
			default: begin
			end
		endcase

		// per byte: any hit, lowest hit and population count of a
		for (int g = 0; g < NGRP; g++) begin
			grp    = sv[g*8 +: 8];
			abyte  = s1.a[g*8 +: 8];
			nz[g]  = |grp;
			pos[g] = 3'd0;
			cnt[g] = 4'd0;
			for (int k = 7; k >= 0; k--) begin
				if (grp[k]) begin
					pos[g] = 3'(k);
				end
			end
			for (int k = 0; k < 8; k++) begin
				cnt[g] = cnt[g] + 4'(abyte[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl;
			nz_s2  <= nz;
			pos_s2 <= pos;
			cnt_s2 <= cnt;
		end
	end

endmodule
`default_nettype wire

### sv/bsop_reduce.sv
`default_nettype none
module bsop_reduce #(
	parameter int unsigned SET_BITS = 64,
	parameter int unsigned NGRP     = (SET_BITS + 7) / 8
) (
	input  wire logic              clk,
	input  wire logic              adv,
	input  wire bsop_pkg::s2_t     ctl_s2,
	input  wire logic [NGRP-1:0]        nz_s2,
	input  wire logic [NGRP-1:0][2:0]   pos_s2,
	input  wire logic [NGRP-1:0][3:0]   cnt_s2,
	output bsop_pkg::rsp_t         rsp_s3
);

	localparam logic [bsop_pkg::IDX_W-1:0] TOP_IDX = bsop_pkg::IDX_W'(SET_BITS - 1);

	logic [bsop_pkg::IDX_W-1:0] sum;
	logic [bsop_pkg::IDX_W-1:0] idx;
	logic                       found;
	bsop_pkg::rsp_t             nxt;

	always_comb begin
		sum   = '0;
		idx   = '0;
		found = 1'b0;
		for (int g = 0; g < NGRP; g++) begin
			sum = sum + bsop_pkg::IDX_W'(cnt_s2[g]);
		end
		// lowest non-empty byte wins
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (nz_s2[g]) begin
				found = 1'b1;
				idx   = {1'b0, 3'(g), pos_s2[g]};
			end
		end

		nxt.result_set   = ctl_s2.rset;
		nxt.result_flag  = ctl_s2.rflag;
		nxt.bad_index    = ctl_s2.bad;
		nxt.result_index = '0;
		case (bsop_pkg::op_t'(ctl_s2.op))
			bsop_pkg::OP_POPCOUNT: nxt.result_index = sum;
			bsop_pkg::OP_FIRST,
			bsop_pkg::OP_FIRSTOUT: nxt.result_index = found ? idx : ctl_s2.n;
			bsop_pkg::OP_LAST:     nxt.result_index = found ? (TOP_IDX - idx) : ctl_s2.n;
			bsop_pkg::OP_NEXT: begin
				nxt.result_index = (found && !ctl_s2.bad) ? idx : ctl_s2.n;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s3 <= nxt;
		end
	end

endmodule
`default_nettype wire

### sv/bitset_set_operations_unit.sv
// a request reaches the response after three registered stages (mask, evaluate, reduce)
// throughput: one request per cycle while rsp is not held; the three stages advance together
// a held response freezes all stages, so req_ready follows rsp_ready while the output is full
// reset: asynchronous, clears the stage valid bits and sets set_size to 64
// cfg_ready is always high; write set_size only while no request is in flight (not enforced)
`default_nettype none
module bitset_set_operations_unit #(
	parameter int unsigned SET_BITS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request channel
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire bsop_pkg::req_t              req,
	// response channel
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output bsop_pkg::rsp_t                   rsp,
	// set size register write
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bsop_pkg::IDX_W-1:0]  cfg_data
);

	localparam int unsigned NGRP = (SET_BITS + 7) / 8;

	logic [bsop_pkg::IDX_W-1:0] set_size_q;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       valid_s3;
	logic                       adv;

	bsop_pkg::s1_t              s1;
	bsop_pkg::s2_t              ctl_s2;
	logic [NGRP-1:0]            nz_s2;
	logic [NGRP-1:0][2:0]       pos_s2;
	logic [NGRP-1:0][3:0]       cnt_s2;
	bsop_pkg::rsp_t             rsp_s3;

	// whole pipe moves when the output stage is empty or being drained
	assign adv       = !valid_s3 || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = valid_s3;
	assign rsp       = rsp_s3;
	assign cfg_ready = 1'b1;

	// set size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= bsop_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			set_size_q <= cfg_data;
		end
	end

	// valid bits travel alongside the stage data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: saturate size, mask operands, flag a bad next index
	bsop_front #(
		.SET_BITS(SET_BITS)
	) u_front (
		.clk      (clk),
		.adv      (adv),
		.req      (req),
		.set_size (set_size_q),
		.s1       (s1)
	);

	// stage 2: set operations, predicates, per-byte search and count
	bsop_eval #(
		.SET_BITS(SET_BITS),
		.NGRP    (NGRP)
	) u_eval (
		.clk    (clk),
		.adv    (adv),
		.s1     (s1),
		.ctl_s2 (ctl_s2),
		.nz_s2  (nz_s2),
		.pos_s2 (pos_s2),
		.cnt_s2 (cnt_s2)
	);

	// stage 3: combine bytes into the index or count, form the response
	bsop_reduce #(
		.SET_BITS(SET_BITS),
		.NGRP    (NGRP)
	) u_reduce (
		.clk    (clk),
		.adv    (adv),
		.ctl_s2 (ctl_s2),
		.nz_s2  (nz_s2),
		.pos_s2 (pos_s2),
		.cnt_s2 (cnt_s2),
		.rsp_s3 (rsp_s3)
	);

	// a stalled response must back-pressure the request side
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("request taken while response stalled");

	// no index above SET_BITS
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.result_index <= bsop_pkg::IDX_W'(SET_BITS)))
		else $error("result index out of range");

	// a bad next index carries no set or flag
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.bad_index) |-> (rsp.result_set == '0 && !rsp.result_flag))
		else $error("bad index response with set or flag");

	// the size register takes the written value
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (set_size_q == $past(cfg_data)))
		else $error("set size write lost");

endmodule
`default_nettype wire

### sim/bitset_set_operations_unit_test.sv
`timescale 1ns / 1ps
module bitset_set_operations_unit_test;

	localparam int unsigned TB_SET_BITS  = 64;
	localparam int unsigned PHASE_ITEMS  = 75;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned SETTLE_EDGES = 8;

	// opcode that the block leaves unused, answered with all fields zero
	localparam logic [bsop_pkg::OP_W-1:0] OP_UNUSED = 4'd15;

	localparam logic [bsop_pkg::SET_W-1:0] FULL_SET  = '1;
	localparam logic [bsop_pkg::SET_W-1:0] EMPTY_SET = '0;
	localparam logic [bsop_pkg::SET_W-1:0] PATTERN_A = 64'hA5C3_0F96_1234_8001;
	localparam logic [bsop_pkg::SET_W-1:0] PATTERN_B = 64'h5AC3_F069_1230_8401;

	// one line of the directed part: the request, and where it is obvious the answer
	typedef struct packed {
		bsop_pkg::req_t stim;
		logic           answered;
		bsop_pkg::rsp_t answer;
	} directed_row_t;

	// what one accepted request transfer should come back as
	typedef struct packed {
		logic [bsop_pkg::OP_W-1:0] op;
		bsop_pkg::rsp_t            want;
	} awaited_t;

	localparam int unsigned DIRECTED_COUNT = 25;
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// set operations at the extremes
		'{'{bsop_pkg::OP_AND,        FULL_SET,  FULL_SET,  6'd0},
			1'b1, '{FULL_SET,  1'b0, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_OR,         EMPTY_SET, EMPTY_SET, 6'd0},
			1'b1, '{EMPTY_SET, 1'b0, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_ANDNOT,     FULL_SET,  EMPTY_SET, 6'd0},
			1'b1, '{FULL_SET,  1'b0, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_ANDNOT,     FULL_SET,  FULL_SET,  6'd63},
			1'b1, '{EMPTY_SET, 1'b0, 7'd0,  1'b0}},
		// predicates
		'{'{bsop_pkg::OP_DISJOINT,   EMPTY_SET, EMPTY_SET, 6'd0},
			1'b1, '{EMPTY_SET, 1'b1, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_SUBSET,     FULL_SET,  FULL_SET,  6'd0},
			1'b1, '{EMPTY_SET, 1'b1, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_SUBSET,     FULL_SET,  EMPTY_SET, 6'd0},
			1'b1, '{EMPTY_SET, 1'b0, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_INTERSECTS, FULL_SET,  FULL_SET,  6'd0},
			1'b1, '{EMPTY_SET, 1'b1, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_EQ,         FULL_SET,  FULL_SET,  6'd0},
			1'b1, '{EMPTY_SET, 1'b1, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_NE,         EMPTY_SET, FULL_SET,  6'd0},
			1'b1, '{EMPTY_SET, 1'b1, 7'd0,  1'b0}},
		// less than: lowest differing index decides, equal sets are not less
		'{'{bsop_pkg::OP_LESS,       64'd1,     64'd2,     6'd0},
			1'b1, '{EMPTY_SET, 1'b1, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_LESS,       64'd2,     64'd1,     6'd0},
			1'b1, '{EMPTY_SET, 1'b0, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_LESS,       PATTERN_A, PATTERN_A, 6'd0},
			1'b1, '{EMPTY_SET, 1'b0, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_LESS,       PATTERN_A, PATTERN_B, 6'd0},
			1'b0, '0},
		// counts and searches, 64 means nothing found at the reset size
		'{'{bsop_pkg::OP_POPCOUNT,   FULL_SET,  EMPTY_SET, 6'd0},
			1'b1, '{EMPTY_SET, 1'b0, 7'd64, 1'b0}},
		'{'{bsop_pkg::OP_ISZERO,     EMPTY_SET, FULL_SET,  6'd0},
			1'b1, '{EMPTY_SET, 1'b1, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_FIRST,      EMPTY_SET, FULL_SET,  6'd0},
			1'b1, '{EMPTY_SET, 1'b0, 7'd64, 1'b0}},
		'{'{bsop_pkg::OP_FIRST,      64'h8000_0000_0000_0000, EMPTY_SET, 6'd0},
			1'b1, '{EMPTY_SET, 1'b0, 7'd63, 1'b0}},
		'{'{bsop_pkg::OP_LAST,       64'd1,     EMPTY_SET, 6'd0},
			1'b1, '{EMPTY_SET, 1'b0, 7'd0,  1'b0}},
		'{'{bsop_pkg::OP_NEXT,       FULL_SET,  EMPTY_SET, 6'd63},
			1'b1, '{EMPTY_SET, 1'b0, 7'd64, 1'b0}},
		'{'{bsop_pkg::OP_NEXT,       PATTERN_A, EMPTY_SET, 6'd5},
			1'b0, '0},
		'{'{bsop_pkg::OP_FIRSTOUT,   FULL_SET,  EMPTY_SET, 6'd0},
			1'b1, '{EMPTY_SET, 1'b0, 7'd64, 1'b0}},
		'{'{bsop_pkg::OP_FIRSTOUT,   EMPTY_SET, EMPTY_SET, 6'd0},
			1'b1, '{EMPTY_SET, 1'b0, 7'd0,  1'b0}},
		'{'{OP_UNUSED,               FULL_SET,  FULL_SET,  6'd63},
			1'b1, '0},
		'{'{bsop_pkg::OP_OR,         PATTERN_A, PATTERN_B, 6'd17},
			1'b0, '0}
	};

	// set sizes walked by the random part: tiny, empty, saturating, odd and full
	localparam logic [bsop_pkg::IDX_W-1:0] PHASE_SIZES [8] = '{
		7'd1, 7'd0, 7'd127, 7'd37, 7'd64, 7'd63, 7'd65, 7'd2
	};

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       req_valid = 1'b0;
	logic                       req_ready;
	bsop_pkg::req_t             req       = '0;
	logic                       rsp_valid;
	logic                       rsp_ready = 1'b0;
	bsop_pkg::rsp_t             rsp;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [bsop_pkg::IDX_W-1:0] cfg_data  = '0;

	// answer travelling alongside the request, changed together with the payload
	logic           row_answered = 1'b0;
	bsop_pkg::rsp_t row_answer   = '0;

	// set_size as the block should hold it
	logic [bsop_pkg::IDX_W-1:0] size_shadow = bsop_pkg::SIZE_RESET;

	awaited_t    awaited_results[$];
	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned sent_items   = 0;
	bit          source_eager = 1'b0;
	bit          sink_eager   = 1'b0;

	bitset_set_operations_unit #(
		.SET_BITS (TB_SET_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// live width: register value saturated to the block's width
	function automatic int unsigned live_bits(input logic [bsop_pkg::IDX_W-1:0] size);
		return (size > bsop_pkg::IDX_W'(TB_SET_BITS)) ? TB_SET_BITS : int'(size);
	endfunction

	// lowest member at or above from and below live, else live
	function automatic int unsigned lowest_member(input logic [bsop_pkg::SET_W-1:0] v,
			input int unsigned from, input int unsigned live);
		for (int unsigned i = from; i < live; i++) begin
			if (v[i])
				return i;
		end
		return live;
	endfunction

	// expected response of the set unit for one request at a given set_size
	function automatic bsop_pkg::rsp_t set_unit_result(input bsop_pkg::req_t stim,
			input logic [bsop_pkg::IDX_W-1:0] size);
		int unsigned                live;
		logic [bsop_pkg::SET_W-1:0] mask;
		logic [bsop_pkg::SET_W-1:0] a;
		logic [bsop_pkg::SET_W-1:0] b;
		logic [bsop_pkg::SET_W-1:0] diff;
		bsop_pkg::rsp_t             r;
		live = live_bits(size);
		mask = (live >= bsop_pkg::SET_W) ? FULL_SET : ((64'd1 << live) - 64'd1);
		a    = stim.set_a & mask;
		b    = stim.set_b & mask;
		diff = a ^ b;
		r    = '0;
		case (stim.opcode)
			bsop_pkg::OP_AND:        r.result_set  = a & b;
			bsop_pkg::OP_OR:         r.result_set  = a | b;
			bsop_pkg::OP_ANDNOT:     r.result_set  = a & ~b;
			bsop_pkg::OP_DISJOINT:   r.result_flag = ((a & b) == EMPTY_SET);
			bsop_pkg::OP_SUBSET:     r.result_flag = ((a & ~b) == EMPTY_SET);
			bsop_pkg::OP_INTERSECTS: r.result_flag = ((a & b) != EMPTY_SET);
			bsop_pkg::OP_EQ:         r.result_flag = (a == b);
			bsop_pkg::OP_NE:         r.result_flag = (a != b);
			// isolate the lowest differing bit and see whether a holds it
			bsop_pkg::OP_LESS:       r.result_flag = |(a & diff & (~diff + 64'd1));
			bsop_pkg::OP_POPCOUNT:   r.result_index = bsop_pkg::IDX_W'($countones(a));
			bsop_pkg::OP_ISZERO:     r.result_flag = (a == EMPTY_SET);
			bsop_pkg::OP_FIRST:
				r.result_index = bsop_pkg::IDX_W'(lowest_member(a, 0, live));
			bsop_pkg::OP_LAST: begin
				r.result_index = bsop_pkg::IDX_W'(live);
				for (int i = int'(live) - 1; i >= 0; i--) begin
					if (a[i]) begin
						r.result_index = bsop_pkg::IDX_W'(i);
						break;
					end
				end
			end
			bsop_pkg::OP_NEXT: begin
				if (int'(stim.query_index) >= int'(live)) begin
					r.bad_index    = 1'b1;
					r.result_index = bsop_pkg::IDX_W'(live);
				end else begin
					r.result_index = bsop_pkg::IDX_W'(
						lowest_member(a, int'(stim.query_index) + 1, live));
				end
			end
			bsop_pkg::OP_FIRSTOUT:
				r.result_index = bsop_pkg::IDX_W'(lowest_member(~a & mask, 0, live));
			default: ;
		endcase
		return r;
	endfunction

	// operand with a mix of shapes, sparse and dense ones kept mostly in the live range
	function automatic logic [bsop_pkg::SET_W-1:0] random_set(input int unsigned span);
		logic [bsop_pkg::SET_W-1:0] v;
		int unsigned                pos;
		case ($urandom_range(0, 5))
			0: v = EMPTY_SET;
			1: v = FULL_SET;
			2: begin
				v = EMPTY_SET;
				repeat ($urandom_range(1, 3)) begin
					pos    = $urandom_range(0, span);
					v[pos] = 1'b1;
				end
			end
			3: begin
				v = FULL_SET;
				repeat ($urandom_range(1, 3)) begin
					pos    = $urandom_range(0, span);
					v[pos] = 1'b0;
				end
			end
			4: v = {$urandom, $urandom} & {$urandom, $urandom};
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// b is often related to a so that equality, subset and less see close calls
	function automatic bsop_pkg::req_t random_request(input int unsigned live);
		bsop_pkg::req_t stim;
		int unsigned    span;
		span = (live == 0 || $urandom_range(0, 3) == 0) ? bsop_pkg::SET_W - 1 : live - 1;
		stim.opcode = ($urandom_range(0, 19) == 0) ? OP_UNUSED
			: bsop_pkg::OP_W'($urandom_range(bsop_pkg::OP_AND, bsop_pkg::OP_FIRSTOUT));
		stim.set_a = random_set(span);
		case ($urandom_range(0, 4))
			0: stim.set_b = stim.set_a;
			1: stim.set_b = stim.set_a ^ (64'd1 << $urandom_range(0, span));
			2: stim.set_b = stim.set_a & random_set(span);
			3: stim.set_b = stim.set_a | random_set(span);
			default: stim.set_b = random_set(span);
		endcase
		stim.query_index = ($urandom_range(0, 1) == 0)
			? bsop_pkg::Q_W'($urandom_range(0, bsop_pkg::SET_W - 1))
			: bsop_pkg::Q_W'($urandom_range(0, span));
		return stim;
	endfunction

	// one request transfer after a random gap; called and returning on a rising edge
	task automatic send_request(input bsop_pkg::req_t stim, input logic answered,
			input bsop_pkg::rsp_t answer);
		int unsigned gap;
		if (sent_items % 32 == 0)
			source_eager = ($urandom_range(0, 3) == 0);
		gap = source_eager ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		req          <= stim;
		row_answered <= answered;
		row_answer   <= answer;
		do
			@(posedge clk);
		while (!req_ready);
		sent_items++;
	endtask

	// hold off new requests until every response is back
	task automatic drain_results();
		req_valid <= 1'b0;
		@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// set_size is only touched with the pipeline empty
	task automatic write_set_size(input logic [bsop_pkg::IDX_W-1:0] size);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= size;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset size
		for (int unsigned k = 0; k < DIRECTED_COUNT; k++)
			send_request(DIRECTED_ROWS[k].stim, DIRECTED_ROWS[k].answered,
				DIRECTED_ROWS[k].answer);

		// random part, one set_size per phase
		for (int unsigned phase = 0; phase < $size(PHASE_SIZES); phase++) begin
			write_set_size(PHASE_SIZES[phase]);
			for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
				// one full stop in the middle of a phase
				if (phase == 3 && k == PHASE_ITEMS / 2)
					drain_results();
				send_request(random_request(live_bits(PHASE_SIZES[phase])), 1'b0, '0);
			end
		end

		drain_results();
		repeat (SETTLE_EDGES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// response side: random stall before each transfer, with eager stretches
	initial begin : response_sink
		int unsigned stall;
		int unsigned served;
		served = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (served % 32 == 0)
				sink_eager = ($urandom_range(0, 3) == 0);
			stall = sink_eager ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_valid);
			served++;
		end
	end

	// predict on request transfers, compare on response transfers
	always @(posedge clk) begin : response_check
		awaited_t entry;
		awaited_t oldest;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				size_shadow = cfg_data;

			if (req_valid && req_ready) begin
				entry.op   = req.opcode;
				entry.want = row_answered ? row_answer : set_unit_result(req, size_shadow);
				awaited_results.push_back(entry);
			end

			if (rsp_valid && rsp_ready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected response transfer: set %h flag %b index %0d bad %b",
							rsp.result_set, rsp.result_flag, rsp.result_index, rsp.bad_index);
				end else begin
					oldest = awaited_results.pop_front();
					if (rsp.result_set !== oldest.want.result_set
							|| rsp.result_flag !== oldest.want.result_flag
							|| rsp.result_index !== oldest.want.result_index
							|| rsp.bad_index !== oldest.want.bad_index) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"op %0d: expected set %h flag %b index %0d bad %b, ",
								"got set %h flag %b index %0d bad %b"},
								oldest.op, oldest.want.result_set, oldest.want.result_flag,
								oldest.want.result_index, oldest.want.bad_index,
								rsp.result_set, rsp.result_flag, rsp.result_index,
								rsp.bad_index);
					end
				end
			end

			// cycles in a row without any transfer
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("no transfer for %0d cycles", QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

endmodule
